FILE: hdl/plbe_pkg.sv
// ----------------------------------------------------------------------------
// plbe_pkg: shared definitions for the polyline length bounds block
// Default widths, fixed field widths, the relation codes and the control struct.
// ----------------------------------------------------------------------------
package plbe_pkg;

  // Default configuration of the block.
  localparam int COORD_BITS_DEF = 24;
  localparam int SUM_BITS_DEF   = 48;

  // Fixed field widths.
  localparam int ERR_W = 22;
  localparam int LEN_W = 48;
  localparam int REL_W = 3;

  // Relation between the previous and the current square.
  typedef enum logic [REL_W-1:0] {
    REL_START   = 3'd0,
    REL_NONE    = 3'd1,
    REL_X_ONLY  = 3'd2,
    REL_Y_ONLY  = 3'd3,
    REL_BOTH    = 3'd4,
    REL_IDENT   = 3'd5
  } rel_t;

  // Control result of the classification stage.
  typedef struct packed {
    rel_t rel;
    logic need_lo;
  } geom_ctl_t;

endpackage

FILE: hdl/plbe_sqrt.sv
// ----------------------------------------------------------------------------
// plbe_sqrt: floor of sqrt(dx*dx + dy*dy), one root bit per cycle
// Squares both legs, adds them, then runs a restoring digit-serial root that
// consumes two radicand bits per cycle.
// ----------------------------------------------------------------------------
module plbe_sqrt #(
  parameter int DW = plbe_pkg::COORD_BITS_DEF + 2
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [DW-1:0]     dx,
  input  logic [DW-1:0]     dy,
  output logic              busy,
  output logic              done,
  output logic [DW:0]       root
);

  localparam int RW = DW + 1;
  localparam int NW = 2 * RW;
  localparam int CNW = $clog2(RW);

  typedef enum logic [1:0] {S_IDLE, S_MUL, S_ADD, S_RUN} sq_state_t;

  sq_state_t          state_r, state_nxt;
  logic               done_r, done_nxt;
  logic [DW-1:0]      dx_r, dx_nxt, dy_r, dy_nxt;
  logic [2*DW-1:0]    sqx_r, sqx_nxt, sqy_r, sqy_nxt;
  logic [NW-1:0]      rad_r, rad_nxt;
  logic [RW:0]        rem_r, rem_nxt;
  logic [RW-1:0]      root_r, root_nxt;
  logic [CNW-1:0]     cnt_r, cnt_nxt;
  logic [RW+2:0]      rem_sh, trial, rem_diff;

  // One digit step of the restoring root.
  assign rem_sh   = {rem_r, rad_r[NW-1:NW-2]};
  assign trial    = {1'b0, root_r, 2'b01};
  assign rem_diff = rem_sh - trial;

  always_comb begin
    state_nxt = state_r;
    done_nxt  = 1'b0;
    dx_nxt    = dx_r;
    dy_nxt    = dy_r;
    sqx_nxt   = sqx_r;
    sqy_nxt   = sqy_r;
    rad_nxt   = rad_r;
    rem_nxt   = rem_r;
    root_nxt  = root_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          dx_nxt    = dx;
          dy_nxt    = dy;
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        sqx_nxt   = dx_r * dx_r;
        sqy_nxt   = dy_r * dy_r;
        state_nxt = S_ADD;
      end
      S_ADD: begin
        rad_nxt   = NW'(sqx_r) + NW'(sqy_r);
        rem_nxt   = '0;
        root_nxt  = '0;
        cnt_nxt   = CNW'(RW - 1);
        state_nxt = S_RUN;
      end
      S_RUN: begin
        rad_nxt = {rad_r[NW-3:0], 2'b00};
        if (rem_sh >= trial) begin
          rem_nxt  = rem_diff[RW:0];
          root_nxt = {root_r[RW-2:0], 1'b1};
        end else begin
          rem_nxt  = rem_sh[RW:0];
          root_nxt = {root_r[RW-2:0], 1'b0};
        end
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          done_nxt  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
    dx_r   <= dx_nxt;
    dy_r   <= dy_nxt;
    sqx_r  <= sqx_nxt;
    sqy_r  <= sqy_nxt;
    rad_r  <= rad_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
    cnt_r  <= cnt_nxt;
  end

  assign busy = (state_r != S_IDLE);
  assign done = done_r;
  assign root = root_r;

endmodule

FILE: hdl/plbe_geom.sv
// ----------------------------------------------------------------------------
// plbe_geom: square classification stage
// Holds the previous square, widens each vertex into a square and registers
// the relation, the minimal gap and the legs of both segment lengths.
// ----------------------------------------------------------------------------
module plbe_geom #(
  parameter int COORD_BITS = plbe_pkg::COORD_BITS_DEF,
  localparam int BW = ((COORD_BITS > plbe_pkg::ERR_W) ? COORD_BITS
                                                       : plbe_pkg::ERR_W + 1) + 1
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          load,
  input  logic [COORD_BITS-1:0]         coord_x,
  input  logic [COORD_BITS-1:0]         coord_y,
  input  logic                          start_path,
  input  logic [plbe_pkg::ERR_W-1:0]    err,
  output plbe_pkg::geom_ctl_t           ctl,
  output logic [BW:0]                   gap,
  output logic [BW:0]                   lo_dx,
  output logic [BW:0]                   lo_dy,
  output logic [BW:0]                   hi_dx,
  output logic [BW:0]                   hi_dy
);

  localparam int DW = BW + 1;

  logic signed [BW-1:0] pxl_r, pxh_r, pyl_r, pyh_r;
  logic signed [BW-1:0] x_s, y_s, e_s, axl, axh, ayl, ayh;
  logic                 xo, yo, right, above, ident;
  logic [DW-1:0]        m_axl_pxh, m_axh_pxl, m_ayl_pyh, m_ayh_pyl;
  plbe_pkg::geom_ctl_t  ctl_r, ctl_nxt;
  logic [DW-1:0]        gap_r, gap_nxt, lo_dx_r, lo_dx_nxt, lo_dy_r, lo_dy_nxt;
  logic [DW-1:0]        hi_dx_r, hi_dx_nxt, hi_dy_r, hi_dy_nxt;

  function automatic logic [DW-1:0] mag(input logic signed [BW-1:0] a,
                                        input logic signed [BW-1:0] b);
    logic signed [DW-1:0] d;
    d = {a[BW-1], a} - {b[BW-1], b};
    return d[DW-1] ? DW'(-d) : DW'(d);
  endfunction

  // Current square.
  assign x_s = {{(BW-COORD_BITS){coord_x[COORD_BITS-1]}}, coord_x};
  assign y_s = {{(BW-COORD_BITS){coord_y[COORD_BITS-1]}}, coord_y};
  assign e_s = {{(BW-plbe_pkg::ERR_W){1'b0}}, err};
  assign axl = x_s - e_s;
  assign axh = x_s + e_s;
  assign ayl = y_s - e_s;
  assign ayh = y_s + e_s;

  // Overlap tests and the edge distances between both squares that every case draws from.
  assign right = pxh_r < axl;
  assign above = pyh_r < ayl;
  assign xo    = !(right || (axh < pxl_r));
  assign yo    = !(above || (ayh < pyl_r));
  assign ident = xo && yo && (pxl_r == axl) && (pxh_r == axh) &&
                 (pyl_r == ayl) && (pyh_r == ayh);
  assign m_axl_pxh = mag(axl, pxh_r);
  assign m_axh_pxl = mag(axh, pxl_r);
  assign m_ayl_pyh = mag(ayl, pyh_r);
  assign m_ayh_pyl = mag(ayh, pyl_r);

  always_comb begin
    ctl_nxt.rel     = plbe_pkg::REL_START;
    ctl_nxt.need_lo = 1'b0;
    gap_nxt   = '0;
    lo_dx_nxt = right ? m_axl_pxh : m_axh_pxl;
    lo_dy_nxt = above ? m_ayl_pyh : m_ayh_pyl;
    hi_dx_nxt = (pxh_r < axh) ? m_axh_pxl : m_axl_pxh;
    hi_dy_nxt = (pyh_r < ayh) ? m_ayh_pyl : m_ayl_pyh;
    if (start_path) begin
      ctl_nxt.rel = plbe_pkg::REL_START;
    end else if (ident) begin
      ctl_nxt.rel = plbe_pkg::REL_IDENT;
    end else if (!xo && !yo) begin
      ctl_nxt.rel     = plbe_pkg::REL_NONE;
      ctl_nxt.need_lo = 1'b1;
      hi_dx_nxt = right ? m_axh_pxl : m_axl_pxh;
      hi_dy_nxt = above ? m_ayh_pyl : m_ayl_pyh;
    end else if (xo && !yo) begin
      ctl_nxt.rel = plbe_pkg::REL_X_ONLY;
      gap_nxt   = above ? m_ayl_pyh : m_ayh_pyl;
      hi_dy_nxt = above ? m_ayh_pyl : m_ayl_pyh;
      hi_dx_nxt = (axh < pxh_r) ? m_axl_pxh : m_axh_pxl;
    end else if (!xo && yo) begin
      ctl_nxt.rel = plbe_pkg::REL_Y_ONLY;
      gap_nxt   = right ? m_axl_pxh : m_axh_pxl;
      hi_dx_nxt = right ? m_axh_pxl : m_axl_pxh;
      hi_dy_nxt = (ayh > pyh_r) ? m_ayh_pyl : m_ayl_pyh;
    end else begin
      ctl_nxt.rel = plbe_pkg::REL_BOTH;
    end
  end

  // Result registers and the stored square.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pxl_r <= '0;
      pxh_r <= '0;
      pyl_r <= '0;
      pyh_r <= '0;
      ctl_r <= '{rel: plbe_pkg::REL_START, need_lo: 1'b0};
    end else if (load) begin
      ctl_r <= ctl_nxt;
      if (ctl_nxt.rel != plbe_pkg::REL_IDENT) begin
        pxl_r <= axl;
        pxh_r <= axh;
        pyl_r <= ayl;
        pyh_r <= ayh;
      end
    end
    if (load) begin
      gap_r   <= gap_nxt;
      lo_dx_r <= lo_dx_nxt;
      lo_dy_r <= lo_dy_nxt;
      hi_dx_r <= hi_dx_nxt;
      hi_dy_r <= hi_dy_nxt;
    end
  end

  assign ctl   = ctl_r;
  assign gap   = gap_r;
  assign lo_dx = lo_dx_r;
  assign lo_dy = lo_dy_r;
  assign hi_dx = hi_dx_r;
  assign hi_dy = hi_dy_r;

endmodule

FILE: hdl/polyline_length_error_bounds.sv
// Only the maximal length needs a root when the squares overlap in at least
// one axis, and both lengths need one when the squares do not overlap at all;
// identical squares and path starts need no root. RW is the root width, the
// bound width plus two (27 at the default 24-bit coordinates). The shared
// square root unit squares and adds the legs, then yields one root bit per
// cycle. One vertex is in work at a time; a finished result waits in the
// output register while the next vertex is taken.
// ----------------------------------------------------------------------------
// polyline_length_error_bounds: running min/max polyline length under error
// Classifies successive error squares, adds segment lengths to saturating
// sums and delivers one result transaction per vertex.
// ----------------------------------------------------------------------------
module polyline_length_error_bounds #(
  parameter int COORD_BITS = plbe_pkg::COORD_BITS_DEF,
  parameter int SUM_BITS   = plbe_pkg::SUM_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [plbe_pkg::ERR_W-1:0]   cfg_wdata,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [COORD_BITS-1:0]        in_coord_x,
  input  logic [COORD_BITS-1:0]        in_coord_y,
  input  logic                         in_start_path,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [plbe_pkg::LEN_W-1:0]   out_length_min,
  output logic [plbe_pkg::LEN_W-1:0]   out_length_max,
  output logic [plbe_pkg::REL_W-1:0]   out_relation,
  output logic                         out_saturated
);

  localparam int BW = ((COORD_BITS > plbe_pkg::ERR_W) ? COORD_BITS
                                                       : plbe_pkg::ERR_W + 1) + 1;
  localparam int DW = BW + 1;
  localparam int RW = DW + 1;
  localparam int XW = ((SUM_BITS > RW) ? SUM_BITS : RW) + 1;

  typedef enum logic [2:0] {ST_IDLE, ST_CLASS, ST_LO, ST_HI, ST_OUT} state_t;

  state_t                     state_r, state_nxt;
  logic [plbe_pkg::ERR_W-1:0] err_r;
  logic [SUM_BITS-1:0]        sum_min_r, sum_min_nxt, sum_max_r, sum_max_nxt;
  logic                       sat_r, sat_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic [plbe_pkg::LEN_W-1:0] out_min_r, out_min_nxt, out_max_r, out_max_nxt;
  logic [plbe_pkg::REL_W-1:0] out_rel_r, out_rel_nxt;
  logic                       out_sat_r, out_sat_nxt;

  logic                       in_take;
  plbe_pkg::geom_ctl_t        g_ctl;
  logic [DW-1:0]              g_gap, g_lo_dx, g_lo_dy, g_hi_dx, g_hi_dy;

  logic                       sq_start, sq_busy, sq_done, sq_use_lo;
  logic [RW-1:0]              sq_root;
  logic [DW-1:0]              sq_dx, sq_dy;

  logic [SUM_BITS-1:0]        add_a;
  logic [XW-1:0]              add_v, add_s;
  logic                       add_ovf;
  logic [SUM_BITS-1:0]        add_res;

  assign in_take = in_valid && !in_stall;

  plbe_geom #(.COORD_BITS(COORD_BITS)) u_geom (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (in_take),
    .coord_x    (in_coord_x),
    .coord_y    (in_coord_y),
    .start_path (in_start_path),
    .err        (err_r),
    .ctl        (g_ctl),
    .gap        (g_gap),
    .lo_dx      (g_lo_dx),
    .lo_dy      (g_lo_dy),
    .hi_dx      (g_hi_dx),
    .hi_dy      (g_hi_dy)
  );

  // The root unit runs the minimal segment first when one is needed.
  assign sq_dx = sq_use_lo ? g_lo_dx : g_hi_dx;
  assign sq_dy = sq_use_lo ? g_lo_dy : g_hi_dy;

  plbe_sqrt #(.DW(DW)) u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sq_start),
    .dx    (sq_dx),
    .dy    (sq_dy),
    .busy  (sq_busy),
    .done  (sq_done),
    .root  (sq_root)
  );

  // Shared saturating adder; the maximal sum only grows in ST_HI.
  assign add_a   = (state_r == ST_HI) ? sum_max_r : sum_min_r;
  assign add_v   = (state_r == ST_CLASS) ? XW'(g_gap) : XW'(sq_root);
  assign add_s   = XW'(add_a) + add_v;
  assign add_ovf = (add_s > XW'({SUM_BITS{1'b1}}));
  assign add_res = add_ovf ? {SUM_BITS{1'b1}} : add_s[SUM_BITS-1:0];

  always_comb begin
    state_nxt     = state_r;
    sum_min_nxt   = sum_min_r;
    sum_max_nxt   = sum_max_r;
    sat_nxt       = sat_r;
    sq_start      = 1'b0;
    sq_use_lo     = 1'b0;
    out_valid_nxt = out_valid_r && out_stall;
    out_min_nxt   = out_min_r;
    out_max_nxt   = out_max_r;
    out_rel_nxt   = out_rel_r;
    out_sat_nxt   = out_sat_r;
    case (state_r)
      ST_IDLE: begin
        if (in_take) begin
          state_nxt = ST_CLASS;
        end
      end
      ST_CLASS: begin
        case (g_ctl.rel)
          plbe_pkg::REL_START: begin
            sum_min_nxt = '0;
            sum_max_nxt = '0;
            sat_nxt     = 1'b0;
            state_nxt   = ST_OUT;
          end
          plbe_pkg::REL_IDENT: begin
            state_nxt = ST_OUT;
          end
          plbe_pkg::REL_NONE: begin
            sq_start  = 1'b1;
            sq_use_lo = 1'b1;
            state_nxt = ST_LO;
          end
          plbe_pkg::REL_X_ONLY, plbe_pkg::REL_Y_ONLY: begin
            sum_min_nxt = add_res;
            sat_nxt     = sat_r || add_ovf;
            sq_start    = 1'b1;
            state_nxt   = ST_HI;
          end
          default: begin
            sq_start  = 1'b1;
            state_nxt = ST_HI;
          end
        endcase
      end
      ST_LO: begin
        if (sq_done) begin
          sum_min_nxt = add_res;
          sat_nxt     = sat_r || add_ovf;
          sq_start    = 1'b1;
          state_nxt   = ST_HI;
        end
      end
      ST_HI: begin
        if (sq_done) begin
          sum_max_nxt = add_res;
          sat_nxt     = sat_r || add_ovf;
          state_nxt   = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_min_nxt   = plbe_pkg::LEN_W'(sum_min_r);
          out_max_nxt   = plbe_pkg::LEN_W'(sum_max_r);
          out_rel_nxt   = g_ctl.rel;
          out_sat_nxt   = sat_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control state, sums, configuration and the output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      err_r       <= '0;
      sum_min_r   <= '0;
      sum_max_r   <= '0;
      sat_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sum_min_r   <= sum_min_nxt;
      sum_max_r   <= sum_max_nxt;
      sat_r       <= sat_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        err_r <= cfg_wdata;
      end
    end
    out_min_r <= out_min_nxt;
    out_max_r <= out_max_nxt;
    out_rel_r <= out_rel_nxt;
    out_sat_r <= out_sat_nxt;
  end

  assign in_stall       = (state_r != ST_IDLE);
  assign out_valid      = out_valid_r;
  assign out_length_min = out_min_r;
  assign out_length_max = out_max_r;
  assign out_relation   = out_rel_r;
  assign out_saturated  = out_sat_r;

  // Between vertices the minimal length never passes the maximal length.
  a_min_le_max: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> (sum_min_r <= sum_max_r))
    else $error("minimal sum exceeds maximal sum");

  // The root unit is only started while it is free.
  a_sq_free: assert property (@(posedge clk) disable iff (!rst_n)
    sq_start |-> !sq_busy) else $error("root unit started while busy");

  // A new result transaction is only raised from the output state.
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_OUT))
    else $error("result raised outside the output state");

  // A root completes only while the sequencer waits for it.
  a_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
    sq_done |-> (state_r == ST_LO || state_r == ST_HI))
    else $error("root finished with no consumer");

endmodule
